// ===== design/bmhq_pkg.sv =====
// Shared types and codes of the binary min-heap priority queue.
package bmhq_pkg;

    // Request codes carried in the mode field
    localparam logic [1:0] MODE_INSERT  = 2'd0;
    localparam logic [1:0] MODE_EXTRACT = 2'd1;
    localparam logic [1:0] MODE_PEEK    = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Request item
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] key_in;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [31:0] key_out;
        logic [1:0]  status;
        logic [6:0]  count_out;
    } out_item_t;

    // Decisions of the shared key comparator
    typedef struct packed {
        logic up_move;  // parent is strictly greater than the sifted key
        logic down_l;   // left child is strictly less than the sifted key
        logic down_r;   // right child wins against the best so far (ties go right)
    } cmp_t;

endpackage

// ===== design/bmhq_cmp.sv =====
// Shared key comparator used by both sift directions.
module bmhq_cmp #(
    parameter int KEY_WIDTH = 32
) (
    input  logic [KEY_WIDTH-1:0] key,
    input  logic [KEY_WIDTH-1:0] a_key,
    input  logic [KEY_WIDTH-1:0] b_key,
    input  logic                 r_ok,
    output bmhq_pkg::cmp_t       result
);

    logic [KEY_WIDTH-1:0] best_key;

    // Sift up: parent in a_key moves down when strictly greater
    assign result.up_move = key < a_key;

    // Sift down: left child in a_key, right child in b_key
    assign result.down_l = a_key < key;
    assign best_key      = result.down_l ? a_key : key;
    assign result.down_r = r_ok && (b_key <= best_key);

endmodule

// ===== design/bmhq_core.sv =====
// Heap storage and sift sequencer of the binary min-heap priority queue.
module bmhq_core #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  bmhq_pkg::in_item_t  in_item,
    output logic                res_valid,
    input  logic                res_ready,
    output bmhq_pkg::out_item_t res_item
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_ROOT,
        S_DOWN,
        S_PEEK,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [KEY_WIDTH-1:0]  key_reg, key_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    bmhq_pkg::out_item_t   res_reg, res_next;

    // Heap memory: one write port, two registered read ports
    logic [KEY_WIDTH-1:0]  heap_mem [CAPACITY];
    logic [KEY_WIDTH-1:0]  rd0_reg, rd1_reg;
    logic                  we;
    logic [AW-1:0]         wa, ra0, ra1;
    logic [KEY_WIDTH-1:0]  wd;

    // Index arithmetic
    logic [CW-1:0]         cnt_m1;
    logic [AW-1:0]         pos_m1, parent_idx, parent_m1, grand_idx;
    logic [CW:0]           cnt_ext, pos_l, pos_r, best_l, best_r;
    logic                  l_in, r_ok;
    logic [AW-1:0]         best_idx;
    logic [KEY_WIDTH-1:0]  best_key;
    bmhq_pkg::cmp_t        cmp;

    assign cnt_m1     = cnt_reg - CW'(1);
    assign pos_m1     = pos_reg - AW'(1);
    assign parent_idx = pos_m1 >> 1;
    assign parent_m1  = parent_idx - AW'(1);
    assign grand_idx  = parent_m1 >> 1;

    assign cnt_ext = (CW+1)'(cnt_reg);
    assign pos_l   = ((CW+1)'(pos_reg) << 1) | (CW+1)'(1);
    assign pos_r   = pos_l + (CW+1)'(1);
    assign l_in    = pos_l < cnt_ext;
    assign r_ok    = pos_r < cnt_ext;

    bmhq_cmp #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_cmp (
        .key    (key_reg),
        .a_key  (rd0_reg),
        .b_key  (rd1_reg),
        .r_ok   (r_ok),
        .result (cmp)
    );

    assign best_idx = cmp.down_r ? AW'(pos_r) : AW'(pos_l);
    assign best_key = cmp.down_r ? rd1_reg : rd0_reg;
    assign best_l   = ((CW+1)'(best_idx) << 1) | (CW+1)'(1);
    assign best_r   = best_l + (CW+1)'(1);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res_item  = res_reg;

    // Sequence one request: decode, sift when inserting or extracting, then hold the result
    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        we         = 1'b0;
        wa         = pos_reg;
        wd         = key_reg;
        ra0        = '0;
        ra1        = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    res_next.key_out   = '0;
                    res_next.status    = bmhq_pkg::ST_OK;
                    res_next.count_out = 7'(cnt_reg);
                    state_next         = S_DONE;
                    unique case (in_item.mode)
                        bmhq_pkg::MODE_INSERT: begin
                            if (cnt_reg >= CW'(CAPACITY)) begin
                                res_next.status = bmhq_pkg::ST_FULL;
                            end else begin
                                key_next           = KEY_WIDTH'(in_item.key_in);
                                pos_next           = AW'(cnt_reg);
                                ra0                = AW'(cnt_m1 >> 1);
                                cnt_next           = cnt_reg + CW'(1);
                                res_next.count_out = 7'(cnt_reg + CW'(1));
                                state_next         = S_UP;
                            end
                        end
                        bmhq_pkg::MODE_EXTRACT: begin
                            if (cnt_reg == '0) begin
                                res_next.status = bmhq_pkg::ST_EMPTY;
                            end else begin
                                ra0                = '0;
                                ra1                = AW'(cnt_m1);
                                cnt_next           = cnt_m1;
                                res_next.count_out = 7'(cnt_m1);
                                state_next         = S_ROOT;
                            end
                        end
                        bmhq_pkg::MODE_PEEK: begin
                            if (cnt_reg == '0) begin
                                res_next.status = bmhq_pkg::ST_EMPTY;
                            end else begin
                                ra0        = '0;
                                state_next = S_PEEK;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // Parent data of pos is in rd0; move it down or settle the key
            S_UP: begin
                we = 1'b1;
                if (pos_reg == '0 || !cmp.up_move) begin
                    wd         = key_reg;
                    state_next = S_DONE;
                end else begin
                    wd       = rd0_reg;
                    pos_next = parent_idx;
                    ra0      = grand_idx;
                end
            end

            // Root in rd0, tail key in rd1; start the sift down from the root
            S_ROOT: begin
                res_next.key_out = 32'(rd0_reg);
                if (cnt_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    key_next   = rd1_reg;
                    pos_next   = '0;
                    ra0        = AW'(1);
                    ra1        = AW'(2);
                    state_next = S_DOWN;
                end
            end

            // Children of pos are in rd0 and rd1; pull the winner up or settle
            S_DOWN: begin
                we = 1'b1;
                if (!l_in || !(cmp.down_l || cmp.down_r)) begin
                    wd         = key_reg;
                    state_next = S_DONE;
                end else begin
                    wd       = best_key;
                    pos_next = best_idx;
                    ra0      = AW'(best_l);
                    ra1      = AW'(best_r);
                end
            end

            S_PEEK: begin
                res_next.key_out = 32'(rd0_reg);
                state_next       = S_DONE;
            end

            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, count, position, sifted key and result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        pos_reg <= pos_next;
        key_reg <= key_next;
        res_reg <= res_next;
    end

    // Write and read the heap memory
    always_ff @(posedge aclk) begin
        if (we) begin
            heap_mem[wa] <= wd;
        end
        rd0_reg <= heap_mem[ra0];
        rd1_reg <= heap_mem[ra1];
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_write_in_heap: assert property (@(posedge aclk) disable iff (!aresetn)
        we |-> (CW+1)'(wa) < cnt_ext)
        else $error("heap write outside stored elements");

    a_sift_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UP || state_reg == S_DOWN) |-> (CW+1)'(pos_reg) < cnt_ext)
        else $error("sift position outside heap");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while another is in flight");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> res_valid && $stable(res_reg))
        else $error("pending result changed");
`endif

endmodule

// ===== design/binary_min_heap_queue.sv =====
// Binary min-heap priority queue: top level with request and result channels.
//
// Requests arrive on s_item (mode, key_in) with s_valid/s_ready; each one
// yields exactly one result on m_item (key_out, status, count_out) with
// m_valid/m_ready. Modes: insert, extract minimum, peek minimum.
// One request is worked at a time. A sequencer walks the heap one level per
// cycle through a memory with one write and two registered read ports and a
// shared key comparator. Rejected and no-op requests go straight to the
// result; peek reads the root; insert sifts the new key up; extract reads
// the root and the tail key and, unless the only key was taken, sifts the
// tail key down from the root. s_ready rises again on the edge that loads
// the result into the output register.
// Reset (aresetn low, synchronous) empties the heap at once; stored keys
// are not cleared and no clearing pass runs.
// While m_ready is low the result stays in the output register; the next
// request is still taken and worked, and its result waits in the sequencer
// until the output register frees up.
module binary_min_heap_queue #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bmhq_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output bmhq_pkg::out_item_t m_item
);

    logic                res_valid, res_ready;
    bmhq_pkg::out_item_t res_item;
    logic                m_valid_reg, m_valid_next;
    bmhq_pkg::out_item_t m_item_reg, m_item_next;

    bmhq_core #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    // Load the output register when it is empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_item_next  = res_item;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
